FILE: hw/rtl/lsds_pkg.sv
// ----------------------------------------------------------------------------
// Largest square scan package
// Request and response types, field widths and register indexes shared by
// the scan block and its response queue.
// ----------------------------------------------------------------------------
package lsds_pkg;

    localparam int CHAR_W    = 8;
    localparam int SIZE_W    = 11;
    localparam int ROW_W     = 16;
    localparam int COL_W     = 10;
    localparam int CFG_IDX_W = 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CHAR    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_CHAR = 1'b1;

    localparam logic [CHAR_W-1:0] EMPTY_CHAR_RESET    = 8'd46;
    localparam logic [CHAR_W-1:0] OBSTACLE_CHAR_RESET = 8'd111;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic              first_of_map;
        logic              last_in_row;
    } t_cell_req;

    typedef struct packed {
        logic [SIZE_W-1:0] square_size;
        logic              new_best;
        logic [SIZE_W-1:0] best_size;
        logic [ROW_W-1:0]  best_row;
        logic [COL_W-1:0]  best_col;
    } t_square_rsp;

endpackage

FILE: hw/rtl/lsds_rsp_queue.sv
// ----------------------------------------------------------------------------
// Largest square scan response queue
// Small circular buffer that decouples the scan pipeline from a stalling
// receiver and reports its fill level.
// ----------------------------------------------------------------------------
module lsds_rsp_queue
    import lsds_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  t_square_rsp            i_data,
    output logic                   o_valid,
    output t_square_rsp            o_data,
    input  logic                   i_stall,
    output logic [QUEUE_CNT_W-1:0] o_count
);

    t_square_rsp            r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < QUEUE_CNT_W'(QUEUE_DEPTH)) || w_pop)
        else $error("response queue overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("response queue pointers disagree with empty count");

endmodule

FILE: hw/rtl/largest_square_dp_scan.sv
// ----------------------------------------------------------------------------
// Largest square scan
// Streaming maximal-square dynamic program over a character grid in raster
// order, with a line buffer of the previous row's square sizes.
// ----------------------------------------------------------------------------
// Usage: grid cells enter on the request channel (i_req_valid, o_req_stall,
// i_req), one character per request, flagged with first_of_map on the first
// cell of a map and last_in_row on the last cell of each row. Every request
// gives exactly one response on (o_rsp_valid, i_rsp_stall, o_rsp) with the
// square size ending at that cell and the best square of the map so far.
// An accepted request passes through the compute stage register and then the
// response queue before it is presented as a response. One request is taken
// per cycle while o_req_stall is low: the line buffer is read when a request
// is accepted and written in the cycle after, and a back-to-back access to
// the same column is forwarded around the memory. When the receiver stalls,
// responses collect in a four-entry queue and o_req_stall rises once the
// queue and the compute stage together hold four responses.
// Synchronous reset clears the counters and the queue, resets the best-square
// record and restores the empty and obstacle codes; the line buffer keeps its
// contents and needs no clearing pass. The two codes are written through
// i_cfg_we, i_cfg_index and i_cfg_data while no request is in flight.
// ----------------------------------------------------------------------------
module largest_square_dp_scan
    import lsds_pkg::*;
#(
    parameter int MAX_COLS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_stall,
    input  t_cell_req            i_req,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_stall,
    output t_square_rsp          o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CHAR_W-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int SW = $clog2(MAX_COLS + 1);

    localparam logic [CW-1:0] LAST_COL = CW'(MAX_COLS - 1);
    localparam logic [SW:0]   SAT_SUM  = (SW + 1)'(MAX_COLS);
    localparam logic [SW-1:0] SAT_SIZE = SW'(MAX_COLS);

    logic [SW-1:0] r_line_mem [MAX_COLS];
    logic [SW-1:0] r_rd_data;

    logic [CHAR_W-1:0] r_empty_char;
    logic [CHAR_W-1:0] r_obstacle_char;

    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    logic              r_s1_v;
    logic [CW-1:0]     r_s1_col;
    logic [ROW_W-1:0]  r_s1_row;
    logic [CHAR_W-1:0] r_s1_char;
    logic              r_s1_first;
    logic              r_s1_fwd;
    logic [SW-1:0]     r_s1_fwd_data;

    logic [SW-1:0]    r_left;
    logic [SW-1:0]    r_diag;
    logic [SW-1:0]    r_best;
    logic [ROW_W-1:0] r_best_row;
    logic [CW-1:0]    r_best_col;

    logic                   w_accept;
    logic [CW-1:0]          w_col;
    logic [ROW_W-1:0]       w_row;
    logic [QUEUE_CNT_W-1:0] w_q_count;
    logic [QUEUE_CNT_W-1:0] w_occupancy;

    logic [SW-1:0]    w_up;
    logic [SW-1:0]    w_min_a;
    logic [SW-1:0]    w_min;
    logic [SW:0]      w_sum;
    logic [SW-1:0]    w_best_base;
    logic [ROW_W-1:0] w_best_row_base;
    logic [CW-1:0]    w_best_col_base;
    logic             n_improved;
    logic [SW-1:0]    n_size;
    logic [SW-1:0]    n_best;
    logic [ROW_W-1:0] n_best_row;
    logic [CW-1:0]    n_best_col;

    logic [SW+SIZE_W-1:0] w_size_ext;
    logic [SW+SIZE_W-1:0] w_best_ext;
    logic [CW+COL_W-1:0]  w_col_ext;
    t_square_rsp          w_rsp;

    // Request side: column and row of the incoming cell.
    assign w_occupancy = w_q_count + QUEUE_CNT_W'(r_s1_v);
    assign o_req_stall = (w_occupancy >= QUEUE_CNT_W'(QUEUE_DEPTH));
    assign w_accept    = i_req_valid && !o_req_stall;
    assign w_col       = i_req.first_of_map ? '0 : r_col;
    assign w_row       = i_req.first_of_map ? '0 : r_row;

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_line_mem[r_s1_col] <= n_size;
        end
        if (w_accept) begin
            r_rd_data <= r_line_mem[w_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_col      <= w_col;
            r_s1_row      <= w_row;
            r_s1_char     <= i_req.cell_char;
            r_s1_first    <= i_req.first_of_map;
            r_s1_fwd      <= r_s1_v && (r_s1_col == w_col);
            r_s1_fwd_data <= n_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_char    <= EMPTY_CHAR_RESET;
            r_obstacle_char <= OBSTACLE_CHAR_RESET;
            r_col           <= '0;
            r_row           <= '0;
            r_s1_v          <= 1'b0;
            r_left          <= '0;
            r_diag          <= '0;
            r_best          <= SW'(1);
            r_best_row      <= '0;
            r_best_col      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EMPTY_CHAR:    r_empty_char    <= i_cfg_data;
                    CFG_OBSTACLE_CHAR: r_obstacle_char <= i_cfg_data;
                    default:           r_empty_char    <= r_empty_char;
                endcase
            end
            r_s1_v <= w_accept;
            if (w_accept) begin
                if (i_req.last_in_row) begin
                    r_col <= '0;
                    r_row <= w_row + 1'b1;
                end else begin
                    r_col <= (w_col == LAST_COL) ? '0 : w_col + 1'b1;
                    r_row <= w_row;
                end
            end
            if (r_s1_v) begin
                r_left     <= n_size;
                r_diag     <= w_up;
                r_best     <= n_best;
                r_best_row <= n_best_row;
                r_best_col <= n_best_col;
            end
        end
    end

    // Compute stage: three-way minimum and best-square record.
    always_comb begin
        w_up    = r_s1_fwd ? r_s1_fwd_data : r_rd_data;
        w_min_a = (r_left < w_up) ? r_left : w_up;
        w_min   = (r_diag < w_min_a) ? r_diag : w_min_a;
        w_sum   = {1'b0, w_min} + 1'b1;

        if (r_s1_char == r_obstacle_char) begin
            n_size = '0;
        end else if (r_s1_char == r_empty_char && r_s1_row != '0 && r_s1_col != '0) begin
            n_size = (w_sum > SAT_SUM) ? SAT_SIZE : w_sum[SW-1:0];
        end else begin
            n_size = SW'(1);
        end

        w_best_base     = r_s1_first ? SW'(1) : r_best;
        w_best_row_base = r_s1_first ? '0 : r_best_row;
        w_best_col_base = r_s1_first ? '0 : r_best_col;

        n_improved = (n_size > w_best_base);
        n_best     = n_improved ? n_size : w_best_base;
        n_best_row = n_improved ? r_s1_row : w_best_row_base;
        n_best_col = n_improved ? r_s1_col : w_best_col_base;
    end

    always_comb begin
        w_size_ext        = {{SIZE_W{1'b0}}, n_size};
        w_best_ext        = {{SIZE_W{1'b0}}, n_best};
        w_col_ext         = {{COL_W{1'b0}}, n_best_col};
        w_rsp.square_size = w_size_ext[SIZE_W-1:0];
        w_rsp.new_best    = n_improved;
        w_rsp.best_size   = w_best_ext[SIZE_W-1:0];
        w_rsp.best_row    = n_best_row;
        w_rsp.best_col    = w_col_ext[COL_W-1:0];
    end

    lsds_rsp_queue u_rsp_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_v),
        .i_data  (w_rsp),
        .o_valid (o_rsp_valid),
        .o_data  (o_rsp),
        .i_stall (i_rsp_stall),
        .o_count (w_q_count)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_v)
        else $error("accepted request did not reach the compute stage");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s1_fwd) |-> $past(r_s1_v))
        else $error("forwarding without a preceding write");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && n_improved) |-> (n_best == n_size && n_best_col == r_s1_col))
        else $error("best record does not match the improving cell");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> (n_best != '0))
        else $error("best size dropped to zero");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Largest square scan testbench
// Streams character grids through the scan block and checks every response
// against an in-bench prediction of the square sizes and best-square record.
// Short directed maps come first. Register writes cover both codes, the case
// where the two codes are equal, and both extremes. Random maps use random
// codes, ragged rows and restarts in the middle of a map. The request side is
// driven in bursts with gaps. The response side stalls on its own pattern,
// including one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import lsds_pkg::*;

    localparam int MAX_COLS = 1024;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 req_valid   = 1'b0;
    logic                 req_stall;
    t_cell_req            req_data    = '0;
    logic                 rsp_valid;
    logic                 rsp_stall   = 1'b0;
    t_square_rsp          rsp_data;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_EMPTY_CHAR;
    logic [CHAR_W-1:0]    cfg_data    = '0;

    t_cell_req   cell_queue[$];
    t_square_rsp pending_squares[$];
    int          fail_count = 0;

    // Prediction state and register copies.
    bit [SIZE_W-1:0]   upper_sizes [MAX_COLS];
    bit [SIZE_W-1:0]   left_sq      = '0;
    bit [SIZE_W-1:0]   diag_sq      = '0;
    bit [SIZE_W-1:0]   best_sq      = SIZE_W'(1);
    bit [ROW_W-1:0]    best_row     = '0;
    bit [COL_W-1:0]    best_col     = '0;
    bit [ROW_W-1:0]    row_cnt      = '0;
    bit [COL_W-1:0]    col_cnt      = '0;
    logic [CHAR_W-1:0] char_empty    = EMPTY_CHAR_RESET;
    logic [CHAR_W-1:0] char_obstacle = OBSTACLE_CHAR_RESET;

    // Raster position of the stimulus and the extent of written buffer columns.
    bit [ROW_W-1:0] gen_row    = '0;
    int             gen_col    = 0;
    int             gen_extent = 0;

    int burst_left = 1;
    int gap_left   = 0;
    int stall_mode = 0;
    int stall_tick = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    largest_square_dp_scan #(
        .MAX_COLS(MAX_COLS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .o_req_stall(req_stall),
        .i_req      (req_data),
        .o_rsp_valid(rsp_valid),
        .i_rsp_stall(rsp_stall),
        .o_rsp      (rsp_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic t_square_rsp predict_square(t_cell_req req);
        t_square_rsp       rsp;
        bit [COL_W-1:0]    col;
        bit [SIZE_W-1:0]   up;
        bit [SIZE_W-1:0]   low;
        bit [SIZE_W-1:0]   sq;
        if (req.first_of_map) begin
            row_cnt  = '0;
            col_cnt  = '0;
            best_sq  = SIZE_W'(1);
            best_row = '0;
            best_col = '0;
        end
        col = col_cnt;
        up  = upper_sizes[col];
        if (req.cell_char == char_obstacle) begin
            sq = '0;
        end else if (req.cell_char == char_empty && row_cnt != 0 && col != 0) begin
            low = up;
            if (left_sq < low) low = left_sq;
            if (diag_sq < low) low = diag_sq;
            sq = (low >= MAX_COLS) ? SIZE_W'(MAX_COLS) : low + 1'b1;
        end else begin
            sq = SIZE_W'(1);
        end
        rsp.new_best = 1'b0;
        if (sq > best_sq) begin
            best_sq      = sq;
            best_row     = row_cnt;
            best_col     = col;
            rsp.new_best = 1'b1;
        end
        diag_sq          = up;
        left_sq          = sq;
        upper_sizes[col] = sq;
        if (req.last_in_row) begin
            col_cnt = '0;
            row_cnt = row_cnt + 1'b1;
        end else begin
            col_cnt = (col == MAX_COLS - 1) ? '0 : col + 1'b1;
        end
        rsp.square_size = sq;
        rsp.best_size   = best_sq;
        rsp.best_row    = best_row;
        rsp.best_col    = best_col;
        return rsp;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Rows after the first are cut short so that no unwritten buffer column is read.
    task automatic push_cell(logic [CHAR_W-1:0] ch, bit is_first, bit is_last);
        t_cell_req item;
        int        next_col;
        if (is_first) begin
            gen_row = '0;
            gen_col = 0;
        end
        if (gen_col >= gen_extent) gen_extent = gen_col + 1;
        next_col = (gen_col == MAX_COLS - 1) ? 0 : gen_col + 1;
        if (gen_row != 0 && next_col >= gen_extent) is_last = 1'b1;
        item.cell_char    = ch;
        item.first_of_map = is_first;
        item.last_in_row  = is_last;
        cell_queue.push_back(item);
        if (is_last) begin
            gen_col = 0;
            gen_row = gen_row + 1'b1;
        end else begin
            gen_col = next_col;
        end
    endtask

    task automatic push_text_row(string text, bit is_first);
        logic [CHAR_W-1:0] ch;
        for (int i = 0; i < text.len(); i++) begin
            case (text[i])
                "." : ch = char_empty;
                "o" : ch = char_obstacle;
                "0" : ch = 8'h00;
                "F" : ch = 8'hFF;
                default: ch = text[i];
            endcase
            push_cell(ch, is_first && i == 0, i == text.len() - 1);
        end
    endtask

    function automatic logic [CHAR_W-1:0] pick_char(int empty_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < empty_pct) return char_empty;
        if (roll < empty_pct + 15) return char_obstacle;
        return CHAR_W'($urandom_range(255));
    endfunction

    task automatic push_random_map(int width, int rows, int empty_pct);
        int len;
        for (int r = 0; r < rows; r++) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(width + 3, 1) : width;
            for (int c = 0; c < len; c++) begin
                push_cell(pick_char(empty_pct),
                          (r == 0 && c == 0) || $urandom_range(199) == 0,
                          c == len - 1 || $urandom_range(99) == 0);
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (cell_queue.size() != 0 || req_valid || pending_squares.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CHAR_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_EMPTY_CHAR) char_empty = value;
        else char_obstacle = value;
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                req_valid <= 1'b0;
            end else if (cell_queue.size() != 0) begin
                req_valid <= 1'b1;
                req_data  <= cell_queue.pop_front();
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(24, 1);
                    gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(3, 1);
                end
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response stall pattern, with one long hold-off once a large backlog is queued.
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
        end else begin
            stall_tick++;
            if (stall_tick % 400 == 0) stall_mode = $urandom_range(3);
            if (!hold_done && cell_queue.size() > 100) begin
                hold_done = 1'b1;
                hold_left = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= $urandom_range(99) < 35;
                    2: rsp_stall <= (stall_tick % 9) < 4;
                    default: rsp_stall <= $urandom_range(99) < 60;
                endcase
            end
        end
    end

    always @(posedge clk) begin
        t_square_rsp want;
        if (rst_n) begin
            if (rsp_valid && !rsp_stall) begin
                if (pending_squares.size() == 0) begin
                    $error("response with no request outstanding");
                    fail_count++;
                end else begin
                    want = pending_squares.pop_front();
                    check_field("square_size", 16'(want.square_size),
                                16'(rsp_data.square_size));
                    check_field("new_best", 16'(want.new_best), 16'(rsp_data.new_best));
                    check_field("best_size", 16'(want.best_size), 16'(rsp_data.best_size));
                    check_field("best_row", want.best_row, rsp_data.best_row);
                    check_field("best_col", 16'(want.best_col), 16'(rsp_data.best_col));
                end
            end
            if (req_valid && !req_stall) pending_squares.push_back(predict_square(req_data));
        end
    end

    initial begin
        int target;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        push_text_row("...0", 1'b1);
        push_text_row("....", 1'b0);
        push_text_row("...F", 1'b0);
        push_text_row("o.x.", 1'b0);

        // Equal codes: the obstacle test takes precedence.
        wait_idle();
        write_reg(CFG_OBSTACLE_CHAR, EMPTY_CHAR_RESET);
        push_text_row(".o", 1'b1);
        push_text_row("..", 1'b0);

        wait_idle();
        write_reg(CFG_EMPTY_CHAR, 8'h00);
        write_reg(CFG_OBSTACLE_CHAR, 8'hFF);
        push_text_row("0F", 1'b1);
        push_text_row("00", 1'b0);

        wait_idle();
        write_reg(CFG_EMPTY_CHAR, 8'hFF);
        write_reg(CFG_OBSTACLE_CHAR, 8'h00);
        push_text_row("F0", 1'b1);
        push_text_row("FF", 1'b0);

        repeat (6) begin
            wait_idle();
            case ($urandom_range(5))
                0: begin
                    write_reg(CFG_EMPTY_CHAR, CHAR_W'($urandom_range(255)));
                    write_reg(CFG_OBSTACLE_CHAR, char_empty);
                end
                1: begin
                    write_reg(CFG_EMPTY_CHAR, EMPTY_CHAR_RESET);
                    write_reg(CFG_OBSTACLE_CHAR, OBSTACLE_CHAR_RESET);
                end
                2: write_reg(CFG_OBSTACLE_CHAR, CHAR_W'($urandom_range(255)));
                default: begin
                    write_reg(CFG_EMPTY_CHAR, CHAR_W'($urandom_range(255)));
                    write_reg(CFG_OBSTACLE_CHAR, CHAR_W'($urandom_range(255)));
                end
            endcase
            target = cell_queue.size() + 170;
            while (cell_queue.size() < target) begin
                push_random_map(($urandom_range(7) == 0) ? $urandom_range(40, 13)
                                                         : $urandom_range(12, 1),
                                $urandom_range(10, 1), $urandom_range(95, 40));
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
